@@ rtl/core/pal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = 8;
    localparam int MOVES_W  = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // read-out tree: groups of GRP cells reduced into one register each
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell in the accept cycle
    typedef struct packed {
        logic                ins;
        logic                app;
        logic                del;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
        logic [DATA_W-1:0]   val;
    } cmd_t;

endpackage

@@ rtl/core/positional_array_list_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed 32-bit entries with insert, append, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel; s_tdata holds operation, position and
//   value. Each request gives one result item on the m_ channel with the read
//   value, status, move count, entry count and empty/full flags.
//   The entries sit in a row of cells. An insert or delete moves every later
//   cell by one place in the accept cycle, so the list update is complete in
//   that cycle whatever the position.
//   The addressed entry comes back through a two-level OR tree (one register
//   per group of eight cells, then the output register that drives m_tdata).
//   One item per cycle is sustained while m_tready is high; the next request
//   already sees the updated list.
//   If the receiver stalls, the finished result waits in the output register
//   and one more item can be taken into the middle stage; s_tready then drops
//   until the output register drains.
//   Reset empties the list (count zero) and clears both stages. Entry
//   contents are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] operation, [9:2] position, [41:10] value, rest zero
    input  logic [pal_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] read_value, [33:32] status, [40:34] moves, [48:41] count,
    // [49] is_empty_flag, [50] is_full_flag, rest zero
    output logic [pal_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [1:0]                  in_op;
    logic [pal_pkg::POS_W-1:0]   in_pos;
    logic [pal_pkg::DATA_W-1:0]  in_val;
    logic                        accept;

    assign in_op  = s_tdata[1:0];
    assign in_pos = s_tdata[9:2];
    assign in_val = s_tdata[41:10];

    // control state
    logic [pal_pkg::CNT_W-1:0]   count_reg;
    logic [pal_pkg::CNT_W-1:0]   count_next;
    logic                        s1_vld_reg;
    logic                        m_vld_reg;

    // stage 1 payload
    pal_pkg::status_t            s1_status_reg, s1_status_next;
    logic [pal_pkg::MOVES_W-1:0] s1_moves_reg, s1_moves_next;
    logic [pal_pkg::CNT_W-1:0]   s1_count_reg;
    logic                        s1_rd_reg, s1_rd_next;

    logic [pal_pkg::M_TDATA_W-1:0] m_tdata_reg;

    pal_pkg::cmd_t               cmd;
    logic [pal_pkg::CMP_W-1:0]   pos_c;
    logic [pal_pkg::CMP_W-1:0]   cnt_c;
    logic                        full;
    logic                        s1_move;

    assign pos_c = pal_pkg::CMP_W'(in_pos);
    assign cnt_c = pal_pkg::CMP_W'(count_reg);
    assign full  = (cnt_c >= pal_pkg::CMP_W'(pal_pkg::CAPACITY));

    assign s1_move  = s1_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        s1_status_next = pal_pkg::ST_OK;
        s1_moves_next  = '0;
        s1_rd_next     = 1'b0;
        count_next     = count_reg;
        cmd.ins        = 1'b0;
        cmd.app        = 1'b0;
        cmd.del        = 1'b0;
        cmd.pos        = in_pos;
        cmd.count      = count_reg;
        cmd.val        = in_val;
        case (pal_pkg::op_t'(in_op))
            pal_pkg::OP_INSERT: begin
                if (full) begin
                    s1_status_next = pal_pkg::ST_FULL;
                end else if (pos_c > cnt_c) begin
                    s1_status_next = pal_pkg::ST_RANGE;
                end else begin
                    cmd.ins       = accept;
                    s1_moves_next = pal_pkg::MOVES_W'(cnt_c - pos_c);
                    count_next    = count_reg + 1'b1;
                end
            end
            pal_pkg::OP_APPEND: begin
                if (full) begin
                    s1_status_next = pal_pkg::ST_FULL;
                end else begin
                    cmd.app    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            pal_pkg::OP_DELETE: begin
                if (pos_c >= cnt_c) begin
                    s1_status_next = pal_pkg::ST_RANGE;
                end else begin
                    cmd.del       = accept;
                    s1_rd_next    = 1'b1;
                    s1_moves_next = pal_pkg::MOVES_W'(cnt_c - pos_c - 1'b1);
                    count_next    = count_reg - 1'b1;
                end
            end
            pal_pkg::OP_READ: begin
                if (pos_c >= cnt_c) begin
                    s1_status_next = pal_pkg::ST_RANGE;
                end else begin
                    s1_rd_next = 1'b1;
                end
            end
            default: begin
                s1_status_next = pal_pkg::ST_OK;
            end
        endcase
    end

    // row of cells
    logic [pal_pkg::DATA_W-1:0] cell_data [pal_pkg::CAPACITY];
    logic [pal_pkg::DATA_W-1:0] rd_pad    [pal_pkg::NGRP*pal_pkg::GRP];
    logic [pal_pkg::DATA_W-1:0] grp_word  [pal_pkg::NGRP];

    for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
        logic [pal_pkg::DATA_W-1:0] left_w;
        logic [pal_pkg::DATA_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == pal_pkg::CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        pal_cell u_cell (
            .aclk    (aclk),
            .cmd     (cmd),
            .idx     (pal_pkg::IDX_W'(i)),
            .left_i  (left_w),
            .right_i (right_w),
            .data_o  (cell_data[i]),
            .rd_o    (rd_pad[i])
        );
    end

    for (genvar i = pal_pkg::CAPACITY; i < pal_pkg::NGRP*pal_pkg::GRP; i++) begin : g_pad
        assign rd_pad[i] = '0;
    end

    for (genvar g = 0; g < pal_pkg::NGRP; g++) begin : g_grp
        logic [pal_pkg::DATA_W-1:0] words [pal_pkg::GRP];
        for (genvar k = 0; k < pal_pkg::GRP; k++) begin : g_w
            assign words[k] = rd_pad[g*pal_pkg::GRP + k];
        end
        pal_rd_group u_grp (
            .aclk    (aclk),
            .en      (accept),
            .words_i (words),
            .grp_o   (grp_word[g])
        );
    end

    logic [pal_pkg::DATA_W-1:0] rd_merge;

    always_comb begin
        rd_merge = '0;
        for (int g = 0; g < pal_pkg::NGRP; g++) begin
            rd_merge = rd_merge | grp_word[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                s1_vld_reg <= 1'b1;
            end else if (s1_move) begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_move) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg <= s1_status_next;
            s1_moves_reg  <= s1_moves_next;
            s1_count_reg  <= count_next;
            s1_rd_reg     <= s1_rd_next;
        end
        if (s1_move) begin
            m_tdata_reg <= {5'd0,
                            (pal_pkg::CMP_W'(s1_count_reg)
                                == pal_pkg::CMP_W'(pal_pkg::CAPACITY)),
                            (s1_count_reg == '0),
                            s1_count_reg,
                            s1_moves_reg,
                            s1_status_reg,
                            (s1_rd_reg ? rd_merge : '0)};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/core/pal_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list entry; shifts to or from its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic                          aclk,
    input  pal_pkg::cmd_t                 cmd,
    input  logic [pal_pkg::IDX_W-1:0]     idx,
    input  logic [pal_pkg::DATA_W-1:0]    left_i,
    input  logic [pal_pkg::DATA_W-1:0]    right_i,
    output logic [pal_pkg::DATA_W-1:0]    data_o,
    output logic [pal_pkg::DATA_W-1:0]    rd_o
);

    logic [pal_pkg::DATA_W-1:0] data_reg;
    logic [pal_pkg::DATA_W-1:0] data_next;
    logic [pal_pkg::CMP_W-1:0]  idx_c;
    logic [pal_pkg::CMP_W-1:0]  pos_c;
    logic [pal_pkg::CMP_W-1:0]  cnt_c;

    assign idx_c = pal_pkg::CMP_W'(idx);
    assign pos_c = pal_pkg::CMP_W'(cmd.pos);
    assign cnt_c = pal_pkg::CMP_W'(cmd.count);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (idx_c > pos_c) begin
                data_next = left_i;
            end else if (idx_c == pos_c) begin
                data_next = cmd.val;
            end
        end else if (cmd.app) begin
            if (idx_c == cnt_c) begin
                data_next = cmd.val;
            end
        end else if (cmd.del) begin
            if (idx_c >= pos_c) begin
                data_next = right_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;
    // contributes to the read-out only when addressed
    assign rd_o   = (idx_c == pos_c) ? data_reg : '0;

endmodule

@@ rtl/core/pal_rd_group.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_rd_group
// First level of the read-out tree: ORs a group of cell outputs into a register.
// ----------------------------------------------------------------------------
module pal_rd_group (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pal_pkg::DATA_W-1:0]  words_i [pal_pkg::GRP],
    output logic [pal_pkg::DATA_W-1:0]  grp_o
);

    logic [pal_pkg::DATA_W-1:0] grp_reg;
    logic [pal_pkg::DATA_W-1:0] grp_next;

    always_comb begin
        grp_next = '0;
        for (int i = 0; i < pal_pkg::GRP; i++) begin
            grp_next = grp_next | words_i[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grp_reg <= grp_next;
        end
    end

    assign grp_o = grp_reg;

endmodule

@@ rtl/core/pal_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks on the positional array list result channel and input back-pressure.
// ----------------------------------------------------------------------------
module pal_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pal_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // input is only held off behind a stalled result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no stalled result");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[49] == (m_tdata[48:41] == 8'd0)))
        else $error("empty flag disagrees with count");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50] == (m_tdata[48:41] == 8'(pal_pkg::CAPACITY))))
        else $error("full flag disagrees with count");

    // an error leaves nothing moved and no value returned
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != pal_pkg::ST_OK)
            |-> (m_tdata[40:34] == 7'd0) && (m_tdata[31:0] == 32'd0))
        else $error("error result carries moves or data");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
